// ===== design/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared definitions for the stage latency tracker
// Default sizes, event codes, segment codes and sequencer states.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 48;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] FUNC_CAPTURE  = 3'd0;
  localparam logic [2:0] FUNC_ESTIMATE = 3'd1;
  localparam logic [2:0] FUNC_CONTROL  = 3'd2;
  localparam logic [2:0] FUNC_ACTUATE  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR    = 3'd4;

  localparam logic [1:0] SEG_CAP_EST = 2'd0;
  localparam logic [1:0] SEG_EST_CTL = 2'd1;
  localparam logic [1:0] SEG_CTL_ACT = 2'd2;
  localparam logic [1:0] SEG_CAP_ACT = 2'd3;

  localparam logic [2:0] SEEN_ALL = 3'b111;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_CHECK,
    ST_EVICT,
    ST_DELTA,
    ST_STAT
  } state_e;

endpackage

// ===== design/stage_latency_tracker.sv =====
// ----------------------------------------------------------------------------
// A capture, estimate or control request stays busy for a walk over every
// table slot, plus a further walk for each entry evicted to meet the capacity.
// An actuate request also walks the table and, when it completes a frame,
// then reports its four segment results in turn. Clear never raises busy.
// The slot walk goes through the single read port of the table memories.
// Reset empties the table, stats and count and sets the capacity to 16.
// ----------------------------------------------------------------------------
// stage_latency_tracker: per-frame stage latency statistics
// Tracks in-flight frames in a table walked by a small sequencer and reports
// per-segment deltas with running min, max, saturating sum and count.
// ----------------------------------------------------------------------------
module stage_latency_tracker import slt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   func_i,
  input  logic [31:0]                  frame_id_i,
  input  logic [TIME_WIDTH-1:0]        timestamp_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CAP_W-1:0]             cfg_data_i,
  output logic                         result_valid_o,
  output logic [1:0]                   segment_o,
  output logic [31:0]                  done_frame_o,
  output logic signed [TIME_WIDTH-1:0] delta_o,
  output logic signed [TIME_WIDTH-1:0] seg_min_o,
  output logic signed [TIME_WIDTH-1:0] seg_max_o,
  output logic signed [63:0]           seg_sum_o,
  output logic [31:0]                  done_count_o,
  output logic                         last_o
);

  localparam int unsigned IDXW = $clog2(TABLE_DEPTH);
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_DEPTH - 1);
  localparam logic signed [TIME_WIDTH-1:0] DMAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [TIME_WIDTH-1:0] DMIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  state_e state_q, state_d;

  logic [CAP_W-1:0]      cap_q;
  logic [2:0]            func_q;
  logic [31:0]           id_q;
  logic [TIME_WIDTH-1:0] ts_q;
  logic                  prune_q;

  logic [IDXW-1:0]       scan_idx_q;
  logic                  rd_vld_q;
  logic [IDXW-1:0]       rd_idx_q;

  logic [31:0]           key_mem [TABLE_DEPTH];
  logic [2:0]            seen_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] cap_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] est_mem [TABLE_DEPTH];
  logic [TIME_WIDTH-1:0] ctl_mem [TABLE_DEPTH];

  logic [31:0]           key_rd_q;
  logic [2:0]            seen_rd_q;
  logic [TIME_WIDTH-1:0] cap_rd_q, est_rd_q, ctl_rd_q;

  logic                  match_q, free_q, min_q;
  logic [IDXW-1:0]       match_idx_q, free_idx_q, min_idx_q;
  logic [31:0]           min_key_q;
  logic [2:0]            match_seen_q;
  logic [TIME_WIDTH-1:0] match_cap_q, match_est_q, match_ctl_q;

  logic [TABLE_DEPTH-1:0] used_q;
  logic [CNTW-1:0]        count_q;

  logic signed [63:0]           stat_sum_q [4];
  logic signed [TIME_WIDTH-1:0] stat_min_q [4];
  logic signed [TIME_WIDTH-1:0] stat_max_q [4];
  logic [31:0]                  total_q;
  logic                         first_q;
  logic [1:0]                   seg_q;
  logic signed [TIME_WIDTH-1:0] delta_q;

  logic                  accept, do_clear, scan_clr, over_cap;
  logic                  wr_en, set_used, clr_used, stat_start, stat_upd;
  logic [IDXW-1:0]       wr_addr, clr_idx;
  logic [2:0]            wr_seen, stage_bit;

  logic                  cmp_used, cmp_hit, cmp_free, cmp_min;

  logic [TIME_WIDTH-1:0] later, earlier;
  logic [TIME_WIDTH:0]   diff;
  logic signed [TIME_WIDTH-1:0] delta_sat;

  logic signed [63:0]           dext, sum_add, sum_new;
  logic signed [TIME_WIDTH-1:0] min_new, max_new;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign do_clear    = accept && (func_i == FUNC_CLEAR);
  assign over_cap    = CMPW'(count_q) > CMPW'(cap_q);
  assign stage_bit   = 3'b001 << func_q[1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (func_i inside {FUNC_CAPTURE, FUNC_ESTIMATE, FUNC_CONTROL,
                                      FUNC_ACTUATE})) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = prune_q ? ST_EVICT : ST_DECIDE;
      ST_DECIDE: begin
        if (func_q == FUNC_ACTUATE) begin
          state_d = (match_q && (match_seen_q == SEEN_ALL)) ? ST_DELTA : ST_IDLE;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK:  state_d = over_cap ? ST_SCAN : ST_IDLE;
      ST_EVICT:  state_d = ST_CHECK;
      ST_DELTA:  state_d = ST_STAT;
      ST_STAT:   state_d = (seg_q == SEG_CAP_ACT) ? ST_IDLE : ST_DELTA;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer actions.
  always_comb begin
    scan_clr   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = match_idx_q;
    wr_seen    = stage_bit;
    set_used   = 1'b0;
    clr_used   = 1'b0;
    clr_idx    = match_idx_q;
    stat_start = 1'b0;
    stat_upd   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        scan_clr = accept;
      end
      ST_DECIDE: begin
        if (func_q == FUNC_ACTUATE) begin
          if (match_q) begin
            clr_used   = 1'b1;
            stat_start = (match_seen_q == SEEN_ALL);
          end
        end else if (match_q) begin
          wr_en   = 1'b1;
          wr_seen = match_seen_q | stage_bit;
        end else if (free_q) begin
          wr_en    = 1'b1;
          wr_addr  = free_idx_q;
          set_used = 1'b1;
        end else if (id_q >= min_key_q) begin
          wr_en   = 1'b1;
          wr_addr = min_idx_q;
        end
      end
      ST_CHECK: begin
        scan_clr = over_cap;
      end
      ST_EVICT: begin
        clr_used = 1'b1;
        clr_idx  = min_idx_q;
      end
      ST_STAT: begin
        stat_upd = 1'b1;
      end
      default: begin
        scan_clr = 1'b0;
      end
    endcase
  end

  // Slot compare on the registered read data.
  assign cmp_used = used_q[rd_idx_q];
  assign cmp_hit  = rd_vld_q && cmp_used && (key_rd_q == id_q);
  assign cmp_free = rd_vld_q && !cmp_used && !free_q;
  assign cmp_min  = rd_vld_q && cmp_used && (!min_q || (key_rd_q < min_key_q));

  // Shared subtractor with saturation to the signed time range.
  always_comb begin
    case (seg_q)
      SEG_CAP_EST: begin later = match_est_q; earlier = match_cap_q; end
      SEG_EST_CTL: begin later = match_ctl_q; earlier = match_est_q; end
      SEG_CTL_ACT: begin later = ts_q;        earlier = match_ctl_q; end
      default:     begin later = ts_q;        earlier = match_cap_q; end
    endcase
    diff = {1'b0, later} - {1'b0, earlier};
    if (diff[TIME_WIDTH] != diff[TIME_WIDTH-1]) begin
      delta_sat = diff[TIME_WIDTH] ? DMIN : DMAX;
    end else begin
      delta_sat = diff[TIME_WIDTH-1:0];
    end
  end

  // Statistics update for the current segment.
  always_comb begin
    dext    = 64'(delta_q);
    sum_add = stat_sum_q[seg_q] + dext;
    if (first_q) begin
      sum_new = dext;
      min_new = delta_q;
      max_new = delta_q;
    end else begin
      if ((stat_sum_q[seg_q][63] == dext[63]) && (sum_add[63] != dext[63])) begin
        sum_new = dext[63] ? SUM_MIN : SUM_MAX;
      end else begin
        sum_new = sum_add;
      end
      min_new = (delta_q < stat_min_q[seg_q]) ? delta_q : stat_min_q[seg_q];
      max_new = (delta_q > stat_max_q[seg_q]) ? delta_q : stat_max_q[seg_q];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cap_q          <= CAP_RESET;
      prune_q        <= 1'b0;
      scan_idx_q     <= '0;
      rd_vld_q       <= 1'b0;
      match_q        <= 1'b0;
      free_q         <= 1'b0;
      min_q          <= 1'b0;
      used_q         <= '0;
      count_q        <= '0;
      total_q        <= '0;
      first_q        <= 1'b0;
      seg_q          <= SEG_CAP_EST;
      result_valid_o <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        stat_sum_q[k] <= '0;
        stat_min_q[k] <= '0;
        stat_max_q[k] <= '0;
      end
    end else begin
      state_q        <= state_d;
      rd_vld_q       <= (state_q == ST_SCAN);
      result_valid_o <= stat_upd;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        prune_q <= 1'b0;
      end else if (state_q == ST_CHECK) begin
        prune_q <= 1'b1;
      end
      if (scan_clr) begin
        scan_idx_q <= '0;
        match_q    <= 1'b0;
        free_q     <= 1'b0;
        min_q      <= 1'b0;
      end else begin
        if (state_q == ST_SCAN) begin
          scan_idx_q <= scan_idx_q + 1'b1;
        end
        if (cmp_hit)  match_q <= 1'b1;
        if (cmp_free) free_q  <= 1'b1;
        if (cmp_min)  min_q   <= 1'b1;
      end
      if (do_clear) begin
        used_q  <= '0;
        count_q <= '0;
        total_q <= '0;
        for (int k = 0; k < 4; k++) begin
          stat_sum_q[k] <= '0;
          stat_min_q[k] <= '0;
          stat_max_q[k] <= '0;
        end
      end else begin
        if (set_used) begin
          used_q[wr_addr] <= 1'b1;
          count_q         <= count_q + 1'b1;
        end
        if (clr_used) begin
          used_q[clr_idx] <= 1'b0;
          count_q         <= count_q - 1'b1;
        end
        if (stat_start) begin
          first_q <= (total_q == '0);
          seg_q   <= SEG_CAP_EST;
          if (total_q != '1) begin
            total_q <= total_q + 1'b1;
          end
        end
        if (stat_upd) begin
          stat_sum_q[seg_q] <= sum_new;
          stat_min_q[seg_q] <= min_new;
          stat_max_q[seg_q] <= max_new;
          seg_q             <= seg_q + 2'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      id_q   <= frame_id_i;
      ts_q   <= timestamp_i;
    end
    rd_idx_q <= scan_idx_q;
    if (cmp_hit) begin
      match_idx_q  <= rd_idx_q;
      match_seen_q <= seen_rd_q;
      match_cap_q  <= cap_rd_q;
      match_est_q  <= est_rd_q;
      match_ctl_q  <= ctl_rd_q;
    end
    if (cmp_free) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmp_min) begin
      min_idx_q <= rd_idx_q;
      min_key_q <= key_rd_q;
    end
    if (state_q == ST_DELTA) begin
      delta_q <= delta_sat;
    end
    if (stat_upd) begin
      segment_o    <= seg_q;
      done_frame_o <= id_q;
      delta_o      <= delta_q;
      seg_min_o    <= min_new;
      seg_max_o    <= max_new;
      seg_sum_o    <= sum_new;
      done_count_o <= total_q;
      last_o       <= (seg_q == SEG_CAP_ACT);
    end
  end

  // Table memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= id_q;
      seen_mem[wr_addr] <= wr_seen;
      case (func_q)
        FUNC_CAPTURE:  cap_mem[wr_addr] <= ts_q;
        FUNC_ESTIMATE: est_mem[wr_addr] <= ts_q;
        default:       ctl_mem[wr_addr] <= ts_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    key_rd_q  <= key_mem[scan_idx_q];
    seen_rd_q <= seen_mem[scan_idx_q];
    cap_rd_q  <= cap_mem[scan_idx_q];
    est_rd_q  <= est_mem[scan_idx_q];
    ctl_rd_q  <= ctl_mem[scan_idx_q];
  end

endmodule

// ===== tb/stage_latency_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_latency_tracker_tb: self-checking testbench for the latency tracker
// Drives capture, estimate, control, actuate and clear requests through the
// start/busy port and changes the table capacity between phases. An internal
// table and statistics tracker predicts the four segment reports of every
// completed frame. Each strobed report is checked field by field.
// ----------------------------------------------------------------------------
module stage_latency_tracker_tb;
  import slt_pkg::*;

  localparam int DEPTH  = TABLE_DEPTH_DEF;
  localparam int TW     = TIME_WIDTH_DEF;
  localparam int TRACES = 6;

  localparam logic signed [63:0] DELTA_MAX = (64'sd1 <<< (TW - 1)) - 64'sd1;
  localparam logic signed [63:0] DELTA_MIN = -DELTA_MAX - 64'sd1;
  localparam logic signed [63:0] SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic [TW-1:0]      TIME_MAX  = '1;

  typedef struct {
    logic [1:0]               segment;
    logic [31:0]              frame;
    logic signed [TW-1:0]     delta;
    logic signed [TW-1:0]     seg_min;
    logic signed [TW-1:0]     seg_max;
    logic signed [63:0]       seg_sum;
    logic [31:0]              count;
    logic                     last;
  } seg_report_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic [2:0]              func_i         = FUNC_CAPTURE;
  logic [31:0]             frame_id_i     = '0;
  logic [TW-1:0]           timestamp_i    = '0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CAP_W-1:0]        cfg_data_i     = CAP_RESET;
  logic                    result_valid_o;
  logic [1:0]              segment_o;
  logic [31:0]             done_frame_o;
  logic signed [TW-1:0]    delta_o;
  logic signed [TW-1:0]    seg_min_o;
  logic signed [TW-1:0]    seg_max_o;
  logic signed [63:0]      seg_sum_o;
  logic [31:0]             done_count_o;
  logic                    last_o;

  // Tracker state mirrored by the testbench.
  bit                      used_q [DEPTH];
  logic [31:0]             key_q [DEPTH];
  logic [2:0]              seen_q [DEPTH];
  logic [TW-1:0]           cap_t [DEPTH];
  logic [TW-1:0]           est_t [DEPTH];
  logic [TW-1:0]           ctl_t [DEPTH];
  logic signed [63:0]      sum_q [4];
  logic signed [TW-1:0]    min_q [4];
  logic signed [TW-1:0]    max_q [4];
  logic [31:0]             total_q;
  logic [CAP_W-1:0]        capacity_q;

  seg_report_t             pending_reports [$];
  int                      errors   = 0;
  int                      idle_pct = 0;

  logic [31:0]             trace_id [TRACES];
  int                      trace_stage [TRACES];
  logic [TW-1:0]           trace_time [TRACES];

  stage_latency_tracker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .frame_id_i     (frame_id_i),
    .timestamp_i    (timestamp_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .segment_o      (segment_o),
    .done_frame_o   (done_frame_o),
    .delta_o        (delta_o),
    .seg_min_o      (seg_min_o),
    .seg_max_o      (seg_max_o),
    .seg_sum_o      (seg_sum_o),
    .done_count_o   (done_count_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_tracker();
    for (int i = 0; i < DEPTH; i++) begin
      used_q[i] = 1'b0;
      key_q[i]  = '0;
      seen_q[i] = '0;
      cap_t[i]  = '0;
      est_t[i]  = '0;
      ctl_t[i]  = '0;
    end
    for (int k = 0; k < 4; k++) begin
      sum_q[k] = '0;
      min_q[k] = '0;
      max_q[k] = '0;
    end
    total_q = '0;
  endfunction

  function automatic int lowest_key_slot();
    int best;
    best = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (used_q[i] && (best < 0 || key_q[i] < key_q[best])) best = i;
    end
    return best;
  endfunction

  function automatic void trim_to_capacity();
    int limit;
    int count;
    int victim;
    limit = (capacity_q > DEPTH) ? DEPTH : int'(capacity_q);
    count = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (used_q[i]) count++;
    end
    while (count > limit) begin
      victim = lowest_key_slot();
      if (victim < 0) break;
      used_q[victim] = 1'b0;
      count--;
    end
  endfunction

  function automatic void record_stage(input logic [2:0] func, input logic [31:0] id,
                                       input logic [TW-1:0] ts);
    int slot;
    int free_slot;
    int victim;
    slot = -1;
    free_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (used_q[i] && key_q[i] == id) slot = i;
      else if (!used_q[i] && free_slot < 0) free_slot = i;
    end
    if (slot < 0) begin
      if (free_slot >= 0) begin
        slot = free_slot;
      end else begin
        victim = lowest_key_slot();
        if (victim < 0 || id < key_q[victim]) begin
          trim_to_capacity();
          return;
        end
        slot = victim;
      end
      used_q[slot] = 1'b1;
      key_q[slot]  = id;
      seen_q[slot] = '0;
      cap_t[slot]  = '0;
      est_t[slot]  = '0;
      ctl_t[slot]  = '0;
    end
    seen_q[slot][func[1:0]] = 1'b1;
    if (func == FUNC_CAPTURE) cap_t[slot] = ts;
    else if (func == FUNC_ESTIMATE) est_t[slot] = ts;
    else ctl_t[slot] = ts;
    trim_to_capacity();
  endfunction

  function automatic logic signed [TW-1:0] clamp_delta(input logic [TW-1:0] earlier,
                                                       input logic [TW-1:0] later);
    logic signed [63:0] diff;
    diff = $signed({{(64 - TW){1'b0}}, later}) - $signed({{(64 - TW){1'b0}}, earlier});
    if (diff > DELTA_MAX) diff = DELTA_MAX;
    else if (diff < DELTA_MIN) diff = DELTA_MIN;
    return diff[TW-1:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? SUM_MIN : SUM_MAX;
    return s;
  endfunction

  function automatic void close_frame(input logic [31:0] id, input logic [TW-1:0] ts);
    int slot;
    logic signed [TW-1:0] d [4];
    logic signed [63:0]   wide;
    seg_report_t          rep;
    slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (used_q[i] && key_q[i] == id) slot = i;
    end
    if (slot < 0) return;
    used_q[slot] = 1'b0;
    if (seen_q[slot] != SEEN_ALL) return;
    d[0] = clamp_delta(cap_t[slot], est_t[slot]);
    d[1] = clamp_delta(est_t[slot], ctl_t[slot]);
    d[2] = clamp_delta(ctl_t[slot], ts);
    d[3] = clamp_delta(cap_t[slot], ts);
    for (int k = 0; k < 4; k++) begin
      wide = d[k];
      if (total_q == 0) begin
        sum_q[k] = wide;
        min_q[k] = d[k];
        max_q[k] = d[k];
      end else begin
        sum_q[k] = add_sat(sum_q[k], wide);
        if (d[k] < min_q[k]) min_q[k] = d[k];
        if (d[k] > max_q[k]) max_q[k] = d[k];
      end
    end
    if (total_q != '1) total_q++;
    for (int k = 0; k < 4; k++) begin
      rep.segment = (k == 0) ? SEG_CAP_EST : (k == 1) ? SEG_EST_CTL :
                    (k == 2) ? SEG_CTL_ACT : SEG_CAP_ACT;
      rep.frame   = id;
      rep.delta   = d[k];
      rep.seg_min = min_q[k];
      rep.seg_max = max_q[k];
      rep.seg_sum = sum_q[k];
      rep.count   = total_q;
      rep.last    = (rep.segment == SEG_CAP_ACT);
      pending_reports.insert(pending_reports.size(), rep);
    end
  endfunction

  function automatic void track_event(input logic [2:0] func, input logic [31:0] id,
                                      input logic [TW-1:0] ts);
    case (func)
      FUNC_CAPTURE, FUNC_ESTIMATE, FUNC_CONTROL: record_stage(func, id, ts);
      FUNC_ACTUATE: close_frame(id, ts);
      FUNC_CLEAR: clear_tracker();
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    seg_report_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, actual segment %0d frame %h",
                 $time, segment_o, done_frame_o);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("segment", want.segment, segment_o);
        check_field("done_frame", want.frame, done_frame_o);
        check_field("delta", want.delta, delta_o);
        check_field("seg_min", want.seg_min, seg_min_o);
        check_field("seg_max", want.seg_max, seg_max_o);
        check_field("seg_sum", want.seg_sum, seg_sum_o);
        check_field("done_count", want.count, done_count_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] w;
    int sel;
    sel = $urandom_range(0, 9);
    w = {$urandom, $urandom};
    if (sel == 0) return '0;
    if (sel == 1) return TIME_MAX;
    return w[TW-1:0];
  endfunction

  // Sends one request and holds start high on return.
  task automatic issue_event(input logic [2:0] func, input logic [31:0] id,
                             input logic [TW-1:0] ts);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= func;
    frame_id_i  <= id;
    timestamp_i <= ts;
    do @(posedge clk_i); while (busy);
    track_event(func, id, ts);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reports.size() != 0);
    repeat (2 * DEPTH + 16) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_quiet();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_q = value;
  endtask

  task automatic test_trace_extremes();
    idle_pct = 35;
    issue_event(FUNC_CAPTURE, 32'h0000_0000, TIME_MAX);
    issue_event(FUNC_ESTIMATE, 32'h0000_0000, '0);
    issue_event(FUNC_CONTROL, 32'h0000_0000, TIME_MAX);
    issue_event(FUNC_ACTUATE, 32'h0000_0000, '0);
    issue_event(FUNC_CAPTURE, 32'hFFFF_FFFF, '0);
    issue_event(FUNC_ESTIMATE, 32'hFFFF_FFFF, TIME_MAX);
    issue_event(FUNC_CONTROL, 32'hFFFF_FFFF, 48'h1234);
    issue_event(FUNC_ACTUATE, 32'hFFFF_FFFF, TIME_MAX);
  endtask

  task automatic test_ignored_events();
    issue_event(3'd5, $urandom, rand_time());
    issue_event(3'd6, $urandom, rand_time());
    issue_event(3'd7, $urandom, rand_time());
    issue_event(FUNC_ACTUATE, 32'h5A5A_5A5A, rand_time());
    issue_event(FUNC_CAPTURE, 32'h0000_0007, 48'h100);
    issue_event(FUNC_CONTROL, 32'h0000_0007, 48'h300);
    issue_event(FUNC_ACTUATE, 32'h0000_0007, 48'h400);
  endtask

  task automatic test_clear();
    issue_event(FUNC_CLEAR, $urandom, rand_time());
    issue_event(FUNC_CAPTURE, 32'hA5A5_0001, 48'h1000);
    issue_event(FUNC_ESTIMATE, 32'hA5A5_0001, 48'h1800);
    issue_event(FUNC_CONTROL, 32'hA5A5_0001, 48'h1900);
    issue_event(FUNC_ACTUATE, 32'hA5A5_0001, 48'h2000);
  endtask

  task automatic test_capacity_edges();
    set_capacity('0);
    issue_event(FUNC_CAPTURE, 32'h0000_0003, 48'h10);
    issue_event(FUNC_ACTUATE, 32'h0000_0003, 48'h20);
    set_capacity(CAP_RESET);
    issue_event(FUNC_CAPTURE, 32'h0000_0001, 48'h10);
    issue_event(FUNC_CAPTURE, 32'h0000_0002, 48'h10);
    issue_event(FUNC_CAPTURE, 32'h0000_0003, 48'h10);
    set_capacity(5'd1);
    issue_event(FUNC_ESTIMATE, 32'h0000_0003, 48'h20);
    issue_event(FUNC_ACTUATE, 32'h0000_0001, 48'h30);
  endtask

  task automatic run_random(input int count, input int fresh_pct);
    int pick;
    int r;
    logic [2:0]    f;
    logic [31:0]   id;
    logic [TW-1:0] ts;
    pick = 0;
    for (int i = 0; i < TRACES; i++) begin
      trace_id[i]    = $urandom;
      trace_stage[i] = 0;
      trace_time[i]  = rand_time();
    end
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        f  = FUNC_CLEAR;
        id = $urandom;
        ts = rand_time();
      end else if (r < 2 + fresh_pct) begin
        f  = 3'($urandom_range(0, 2));
        id = $urandom;
        ts = rand_time();
      end else if (r < 12 + fresh_pct) begin
        f  = 3'($urandom_range(0, 7));
        id = trace_id[$urandom_range(0, TRACES - 1)];
        ts = rand_time();
      end else begin
        if ($urandom_range(0, 99) < 40) pick = $urandom_range(0, TRACES - 1);
        if ($urandom_range(0, 99) < 5) trace_stage[pick] = 3;
        if ($urandom_range(0, 99) < 5) trace_time[pick] = trace_time[pick] + rand_time();
        else trace_time[pick] = trace_time[pick] + TW'($urandom_range(0, 100000));
        f  = (trace_stage[pick] == 0) ? FUNC_CAPTURE : (trace_stage[pick] == 1) ?
             FUNC_ESTIMATE : (trace_stage[pick] == 2) ? FUNC_CONTROL : FUNC_ACTUATE;
        id = trace_id[pick];
        ts = trace_time[pick];
        if (trace_stage[pick] == 3) begin
          trace_stage[pick] = 0;
          if ($urandom_range(0, 99) < 30) begin
            r = $urandom_range(0, 9);
            trace_id[pick]   = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            trace_time[pick] = rand_time();
          end
        end else begin
          trace_stage[pick]++;
        end
      end
      if ($urandom_range(0, 99) < 3) wait_quiet();
      issue_event(f, id, ts);
    end
  endtask

  task automatic test_random_traffic();
    idle_pct = 35;
    set_capacity(CAP_RESET);
    run_random(50, 10);
    set_capacity(5'd31);
    run_random(50, 40);
    idle_pct = 47;
    set_capacity(5'd1);
    run_random(50, 10);
    set_capacity('0);
    run_random(30, 10);
    idle_pct = 0;
    set_capacity(CAP_W'($urandom_range(2, 15)));
    run_random(60, 10);
    set_capacity(CAP_RESET);
    run_random(60, 25);
  endtask

  initial begin
    capacity_q = CAP_RESET;
    clear_tracker();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_trace_extremes();
    test_ignored_events();
    test_clear();
    test_capacity_edges();
    test_random_traffic();
    wait_quiet();
    if (errors == 0) begin
      $display("stage_latency_tracker verification clean");
    end else begin
      $display("stage_latency_tracker verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("stage_latency_tracker verification failed");
    $finish;
  end

endmodule
